/* rtl/pls_pkg.sv */
// Package for the positional list store: request and response types,
// mode codes and fixed field widths. Depends on nothing.
package pls_pkg;

  localparam int unsigned PosW     = 11;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 11;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned Capacity = 1024;

  // Mode codes; the fourth code is unused and always rejected
  localparam logic [ModeW-1:0] ModeInsert = 2'd0;
  localparam logic [ModeW-1:0] ModeDelete = 2'd1;
  localparam logic [ModeW-1:0] ModeRead   = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] new_value;
  } pls_req_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] data_out;
    logic [CountW-1:0]       count_now;
  } pls_rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StShift = 4'b0010,
    StLast  = 4'b0100,
    StFin   = 4'b1000
  } pls_state_e;

endpackage

/* rtl/pls_mem.sv */
// Element store: one write port and one read port, read data registered.
// Depends on pls_pkg for the data width.
module pls_mem #(
  parameter int unsigned Depth = 1024
) (
  input  logic                              clk_i,
  input  logic                              re_i,
  input  logic [$clog2(Depth)-1:0]          raddr_i,
  input  logic                              we_i,
  input  logic [$clog2(Depth)-1:0]          waddr_i,
  input  logic [pls_pkg::DataW-1:0]         wdata_i,
  output logic [pls_pkg::DataW-1:0]         rdata_o
);
  import pls_pkg::*;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pls_seq.sv */
// Request sequencer: checks position against the length, walks the store one
// entry per cycle to shift or read it, and forms the response. Uses pls_pkg.
module pls_seq #(
  parameter int unsigned Capacity = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  pls_pkg::pls_req_t                 req_i,
  output logic                              rsp_valid_o,
  output pls_pkg::pls_rsp_t                 rsp_o,
  output logic                              mem_re_o,
  output logic [$clog2(Capacity)-1:0]       mem_raddr_o,
  output logic                              mem_we_o,
  output logic [$clog2(Capacity)-1:0]       mem_waddr_o,
  output logic [pls_pkg::DataW-1:0]         mem_wdata_o,
  input  logic [pls_pkg::DataW-1:0]         mem_rdata_i
);
  import pls_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned LW = $clog2(Capacity + 1);
  localparam int unsigned CW = ((LW > PosW) ? LW : PosW) + 1;

  pls_state_e       state_q, state_d;
  logic [LW-1:0]    len_q, len_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic             first_q, first_d;
  logic             pend_q, pend_d;
  logic             cap_q, cap_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [AW-1:0]    rd_q, rd_d;
  logic [AW-1:0]    end_q, end_d;
  logic [AW-1:0]    ins_q, ins_d;
  logic [AW-1:0]    waddr_q, waddr_d;
  logic [DataW-1:0] val_q, val_d;
  logic [DataW-1:0] data_q, data_d;
  pls_rsp_t         rsp_q, rsp_d;

  logic [CW-1:0]    pos_c, len_c, posm1_c;
  logic [AW-1:0]    posm1, lenm1;
  logic             ins_ok, rd_ok, is_ins;

  // Position checks on the incoming request
  assign pos_c   = CW'(req_i.position);
  assign len_c   = CW'(len_q);
  assign posm1_c = pos_c - CW'(1);
  assign posm1   = posm1_c[AW-1:0];
  assign lenm1   = AW'(len_c - CW'(1));
  assign ins_ok  = (pos_c != '0) && (pos_c <= len_c + CW'(1)) && (len_c < CW'(Capacity));
  assign rd_ok   = (pos_c != '0) && (pos_c <= len_c);
  assign is_ins  = (mode_q == ModeInsert);

  // Next state, memory port and response
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    first_d     = first_q;
    pend_d      = pend_q;
    cap_d       = cap_q;
    mode_d      = mode_q;
    rd_d        = rd_q;
    end_d       = end_q;
    ins_d       = ins_q;
    waddr_d     = waddr_q;
    val_d       = val_q;
    data_d      = cap_q ? mem_rdata_i : data_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_q;
    // a read issued last cycle is written back now, one entry over
    mem_we_o    = pend_q;
    mem_waddr_o = waddr_q;
    mem_wdata_o = mem_rdata_i;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          mode_d  = req_i.mode;
          val_d   = req_i.new_value;
          ins_d   = posm1;
          first_d = 1'b1;
          data_d  = '0;
          priority if (req_i.mode == ModeInsert && ins_ok) begin
            if (posm1_c == len_c) begin
              state_d = StFin;
            end else begin
              rd_d    = lenm1;
              end_d   = posm1;
              state_d = StShift;
            end
          end else if (req_i.mode == ModeDelete && rd_ok) begin
            rd_d    = posm1;
            end_d   = lenm1;
            state_d = StShift;
          end else if (req_i.mode == ModeRead && rd_ok) begin
            rd_d    = posm1;
            end_d   = posm1;
            state_d = StShift;
          end else begin
            rsp_valid_d     = 1'b1;
            rsp_d.ok        = 1'b0;
            rsp_d.data_out  = '0;
            rsp_d.count_now = CountW'(len_q);
          end
        end
      end
      StShift: begin
        // read and write addresses are always two entries apart: no forwarding
        mem_re_o = 1'b1;
        first_d  = 1'b0;
        pend_d   = is_ins || !first_q;
        cap_d    = !is_ins && first_q;
        waddr_d  = is_ins ? rd_q + AW'(1) : rd_q - AW'(1);
        if (rd_q == end_q) begin
          state_d = StLast;
        end else begin
          rd_d = is_ins ? rd_q - AW'(1) : rd_q + AW'(1);
        end
      end
      StLast: begin
        pend_d  = 1'b0;
        cap_d   = 1'b0;
        state_d = StFin;
      end
      StFin: begin
        if (is_ins) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ins_q;
          mem_wdata_o = val_q;
          len_d       = len_q + LW'(1);
        end else if (mode_q == ModeDelete) begin
          len_d = len_q - LW'(1);
        end
        rsp_valid_d     = 1'b1;
        rsp_d.ok        = 1'b1;
        rsp_d.data_out  = is_ins ? '0 : data_q;
        rsp_d.count_now = CountW'(len_d);
        state_d         = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      rsp_valid_q <= 1'b0;
      first_q     <= 1'b0;
      pend_q      <= 1'b0;
      cap_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rsp_valid_q <= rsp_valid_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
      cap_q       <= cap_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    rd_q    <= rd_d;
    end_q   <= end_d;
    ins_q   <= ins_d;
    waddr_q <= waddr_d;
    val_q   <= val_d;
    data_q  <= data_d;
    rsp_q   <= rsp_d;
  end

  assign busy        = (state_q != StIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* rtl/positional_list_store.sv */
// Top level of the positional list store: sequencer plus element store.
// Depends on pls_pkg, pls_mem and pls_seq.
//
// Usage:
//   A request (mode, position, new_value) is taken at a rising edge where
//   start is high and busy is low. Modes: insert, delete, read; position is
//   1-based. Each request yields one response (ok, data_out, count_now),
//   shown on rsp_o for exactly one cycle while rsp_valid_o is high.
//   The receiver cannot stall; a response is never held back.
// Timing:
//   Rejected request: response in the cycle after acceptance. Other
//   requests pass StShift, StLast and StFin; StShift reads the entry of a
//   read, walks entries p up to n for a delete at p of a length-n list
//   and n down to p for an insert at p. Appends go straight to StFin.
//   The shift moves one entry per cycle through the store's one read port
//   and one write port; busy stays high until the response cycle.
//   A new request may be given in the cycle the response is shown.
// Reset:
//   rst_ni clears the length to zero; store contents are not cleared and
//   entries are only read after they have been written.
module positional_list_store #(
  parameter int unsigned Capacity = pls_pkg::Capacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pls_pkg::pls_req_t  req_i,
  output logic               rsp_valid_o,
  output pls_pkg::pls_rsp_t  rsp_o
);
  import pls_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);

  logic             mem_re, mem_we;
  logic [AW-1:0]    mem_raddr, mem_waddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  // Sequencer
  pls_seq #(
    .Capacity (Capacity)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // Element store
  pls_mem #(
    .Depth (Capacity)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

/* sim/tb.sv */
// Testbench for positional_list_store: drives insert, delete, read and unused
// mode requests, checking every response against a queue-based list model.
// Depends on pls_pkg and the positional_list_store RTL.
`timescale 1ns / 1ps

module tb;
  import pls_pkg::*;

  // The fourth mode code has no name in the package; it must always be rejected
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int CycleLimit = 10_000_000;
  localparam int RandomPerPhase = 175;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  pls_req_t req_i;
  logic     rsp_valid_o;
  pls_rsp_t rsp_o;

  // Model of the list contents, index 0 is position 1
  logic signed [DataW-1:0] list_model[$];
  // Responses still owed by the block, oldest first
  pls_rsp_t                owed_rsp[$];
  pls_rsp_t                want;
  int                      fail_count = 0;
  int                      cycle_count = 0;
  int                      sender_idle_pct;

  positional_list_store i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Apply one request to the list model and return the response it yields
  function automatic pls_rsp_t list_update(input pls_req_t r);
    pls_rsp_t    rsp;
    int unsigned len;
    int unsigned pos;
    len = list_model.size();
    pos = 32'(r.position);
    rsp = '0;
    case (r.mode)
      ModeInsert: begin
        if (pos >= 1 && pos <= len + 1 && len < Capacity) begin
          list_model.insert(pos - 1, r.new_value);
          rsp.ok = 1'b1;
        end
      end
      ModeDelete: begin
        if (pos >= 1 && pos <= len) begin
          rsp.data_out = list_model[pos - 1];
          list_model.delete(pos - 1);
          rsp.ok = 1'b1;
        end
      end
      ModeRead: begin
        if (pos >= 1 && pos <= len) begin
          rsp.data_out = list_model[pos - 1];
          rsp.ok = 1'b1;
        end
      end
      default: ;
    endcase
    rsp.count_now = CountW'(list_model.size());
    return rsp;
  endfunction

  // Offer one request, with random idle cycles first; start stays high on return
  task automatic send_request(input pls_req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    owed_rsp.push_back(list_update(r));
  endtask

  task automatic send_fields(input logic [ModeW-1:0] mode, input int unsigned pos,
                             input logic signed [DataW-1:0] val);
    pls_req_t r;
    r.mode      = mode;
    r.position  = PosW'(pos);
    r.new_value = val;
    send_request(r);
  endtask

  function automatic logic signed [DataW-1:0] random_value();
    logic signed [DataW-1:0] v;
    case ($urandom_range(19))
      0:       v = 32'sh8000_0000;
      1:       v = 32'sh7fff_ffff;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly legal requests on a short list, plus bad positions and the unused mode
  function automatic pls_req_t random_request();
    pls_req_t    r;
    int unsigned len;
    int unsigned roll;
    len = list_model.size();
    roll = $urandom_range(99);
    r.new_value = random_value();
    if (roll < 5) begin
      r.mode     = ModeUnused;
      r.position = PosW'($urandom_range(1025));
    end else if (roll < 12) begin
      r.mode     = ModeW'($urandom_range(2));
      r.position = $urandom_range(1) ? '0 : PosW'($urandom_range(1025, len + 2));
    end else begin
      roll = $urandom_range(99);
      if (len == 0) r.mode = ModeInsert;
      else if (len >= 48) r.mode = (roll < 60) ? ModeDelete : (roll < 80) ? ModeRead : ModeInsert;
      else r.mode = (roll < 45) ? ModeInsert : (roll < 75) ? ModeDelete : ModeRead;
      if (r.mode == ModeInsert) r.position = PosW'($urandom_range(len + 1, 1));
      else r.position = PosW'($urandom_range(len, 1));
    end
    return r;
  endfunction

  // Empty list, bad positions, unused mode and the value extremes
  task automatic test_corner_requests();
    sender_idle_pct = 19;
    send_fields(ModeRead, 1, 32'sd5);
    send_fields(ModeDelete, 1, 32'sd5);
    send_fields(ModeInsert, 0, 32'sd7);
    send_fields(ModeInsert, 2, 32'sd7);
    send_fields(ModeInsert, 1, 32'sh7fff_ffff);
    send_fields(ModeInsert, 1, 32'sh8000_0000);
    send_fields(ModeInsert, 3, 32'sd0);
    send_fields(ModeInsert, 2, -32'sd1);
    send_fields(ModeInsert, 6, 32'sd9);
    send_fields(ModeRead, 0, 32'sd0);
    send_fields(ModeDelete, 0, 32'sd0);
    send_fields(ModeUnused, 1, 32'sh1234_5678);
    send_fields(ModeUnused, 0, 32'sd0);
    for (int p = 1; p <= 4; p++) send_fields(ModeRead, p, 32'sd0);
    send_fields(ModeRead, 5, 32'sd0);
    send_fields(ModeDelete, 5, 32'sd0);
    send_fields(ModeRead, 1025, 32'sd0);
    send_fields(ModeInsert, 1024, 32'sd1);
    send_fields(ModeDelete, 4, 32'sd0);
    send_fields(ModeDelete, 2, 32'sd0);
    send_fields(ModeDelete, 1, 32'sd0);
  endtask

  task automatic test_random_mix(input int idle_pct, input int n);
    sender_idle_pct = idle_pct;
    repeat (n) send_request(random_request());
  endtask

  // Compare each response with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (owed_rsp.size() == 0) begin
        $error("response with none owed: ok %0b data_out %0d count_now %0d",
               rsp_o.ok, rsp_o.data_out, rsp_o.count_now);
        fail_count++;
      end else begin
        want = owed_rsp.pop_front();
        if (rsp_o.ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, rsp_o.ok);
          fail_count++;
        end
        if (rsp_o.data_out !== want.data_out) begin
          $error("data_out: expected %0d, got %0d", want.data_out, rsp_o.data_out);
          fail_count++;
        end
        if (rsp_o.count_now !== want.count_now) begin
          $error("count_now: expected %0d, got %0d", want.count_now, rsp_o.count_now);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    sender_idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_corner_requests();
    test_random_mix(19, RandomPerPhase);
    test_random_mix(47, RandomPerPhase);
    test_random_mix(0, RandomPerPhase);

    // Stop requesting, collect what is owed, then watch for strays
    start <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk_i);
    repeat (Capacity + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
